[rtl/tbp_pkg.sv]
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, codes and character helpers of the text to byte payload
// parser.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // Most result items that one input item can cause:
    // one byte, CR, LF and the status item.
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_PARSE_MODE  = 2'd0;
    localparam logic [1:0] REG_LINE_ENDING = 2'd1;

    // Parse modes
    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_HEX   = 2'd1;
    localparam logic [1:0] MODE_DEC   = 2'd2;
    localparam logic [1:0] MODE_BIN   = 2'd3;

    // Line endings
    localparam logic [1:0] LE_NONE = 2'd0;
    localparam logic [1:0] LE_CR   = 2'd1;
    localparam logic [1:0] LE_LF   = 2'd2;
    localparam logic [1:0] LE_CRLF = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HEX   = 3'd1;
    localparam logic [2:0] ST_ODD_NIB   = 3'd2;
    localparam logic [2:0] ST_BAD_DEC   = 3'd3;
    localparam logic [2:0] ST_BAD_BIN   = 3'd4;
    localparam logic [2:0] ST_NON_ASCII = 3'd5;

    // Characters
    localparam logic [15:0] CH_ASCII_MAX  = 16'h007F;
    localparam logic [15:0] CH_SPACE      = 16'h0020;
    localparam logic [15:0] CH_TAB        = 16'h0009;
    localparam logic [15:0] CH_CR16       = 16'h000D;
    localparam logic [15:0] CH_COMMA      = 16'h002C;
    localparam logic [15:0] CH_SEMI       = 16'h003B;
    localparam logic [15:0] CH_PLUS       = 16'h002B;
    localparam logic [15:0] CH_MINUS      = 16'h002D;
    localparam logic [15:0] CH_ZERO       = 16'h0030;
    localparam logic [15:0] CH_ONE        = 16'h0031;
    localparam logic [15:0] CH_NINE       = 16'h0039;
    localparam logic [15:0] CH_FW_COMMA   = 16'hFF0C;
    localparam logic [15:0] CH_FW_SEMI    = 16'hFF1B;
    localparam logic [15:0] CH_IDEO_COMMA = 16'h3001;
    localparam logic [7:0]  BYTE_CR       = 8'h0D;
    localparam logic [7:0]  BYTE_LF       = 8'h0A;
    localparam logic [8:0]  ACC_SAT       = 9'd256;
    localparam logic [8:0]  ACC_MAX_BYTE  = 9'd255;

    typedef struct packed {
        logic [1:0] parse_mode;
        logic [1:0] line_ending;
    } cfg_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       last_item;
        logic [2:0] status_code;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] res_vec_t;

    // Decimal token flags
    typedef struct packed {
        logic active;
        logic sign;
        logic minus;
        logic digit;
        logic bad;
    } tok_flags_t;

    function automatic result_t make_byte(input logic [7:0] b);
        result_t r;
        r.byte_value  = b;
        r.has_byte    = 1'b1;
        r.last_item   = 1'b0;
        r.status_code = ST_OK;
        return r;
    endfunction

    function automatic logic is_space(input logic [15:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR16);
    endfunction

    function automatic logic is_sep(input logic [15:0] c);
        return is_space(c) || c == CH_COMMA || c == CH_SEMI ||
               c == CH_FW_COMMA || c == CH_FW_SEMI || c == CH_IDEO_COMMA;
    endfunction

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                     (c >= 16'h0041 && c <= 16'h0046)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[rtl/tbp_core.sv]
// ----------------------------------------------------------------------------
// tbp_core
// Message state of the parser and the single-pass decode of one input
// item into up to four result items.
// ----------------------------------------------------------------------------
module tbp_core
    import tbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        fire,
    input  logic [15:0] char_code,
    input  logic        has_char,
    input  logic        end_of_text,
    output res_vec_t    res,
    output logic [RES_CNT_W-1:0] res_cnt
);

    logic [2:0]  error_reg,  error_next;
    logic [3:0]  hn_reg,     hn_next;
    logic        np_reg,     np_next;
    logic [7:0]  bs_reg,     bs_next;
    logic [2:0]  bc_reg,     bc_next;
    logic [8:0]  acc_reg,    acc_next;
    tok_flags_t  tok_reg,    tok_next;

    function automatic logic token_good(input tok_flags_t t, input logic [8:0] a);
        return t.digit && !t.bad && (a <= ACC_MAX_BYTE) && (!t.minus || a == 9'd0);
    endfunction

    always_comb begin
        logic [4:0]  hx;
        logic [11:0] prod;
        logic [RES_CNT_W-1:0] n;
        res_vec_t    r;

        error_next = error_reg;
        hn_next    = hn_reg;
        np_next    = np_reg;
        bs_next    = bs_reg;
        bc_next    = bc_reg;
        acc_next   = acc_reg;
        tok_next   = tok_reg;
        n          = '0;
        r          = '0;
        hx         = hex_digit(char_code);
        prod       = '0;

        if (has_char) begin
            case (cfg.parse_mode)
                MODE_ASCII: begin
                    if (char_code > CH_ASCII_MAX) begin
                        if (error_next == ST_OK) error_next = ST_NON_ASCII;
                    end else if (error_next == ST_OK) begin
                        r[n[1:0]] = make_byte(char_code[7:0]);
                        n = n + 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (!(is_space(char_code) || char_code == CH_COMMA ||
                          char_code == CH_MINUS)) begin
                        if (!hx[4]) begin
                            if (error_next == ST_OK) error_next = ST_BAD_HEX;
                        end else if (np_next) begin
                            if (error_next == ST_OK) begin
                                r[n[1:0]] = make_byte({hn_next, hx[3:0]});
                                n = n + 1'b1;
                            end
                            np_next = 1'b0;
                            hn_next = 4'd0;
                        end else begin
                            hn_next = hx[3:0];
                            np_next = 1'b1;
                        end
                    end
                end
                MODE_DEC: begin
                    if (is_sep(char_code)) begin
                        // close the open token
                        if (tok_next.active) begin
                            if (token_good(tok_next, acc_next)) begin
                                if (error_next == ST_OK) begin
                                    r[n[1:0]] = make_byte(acc_next[7:0]);
                                    n = n + 1'b1;
                                end
                            end else if (error_next == ST_OK) begin
                                error_next = ST_BAD_DEC;
                            end
                        end
                        tok_next = '0;
                        acc_next = '0;
                    end else begin
                        tok_next.active = 1'b1;
                        if ((char_code == CH_PLUS || char_code == CH_MINUS) &&
                            !(tok_next.sign || tok_next.digit)) begin
                            tok_next.sign = 1'b1;
                            if (char_code == CH_MINUS) tok_next.minus = 1'b1;
                        end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
                            prod = {3'd0, acc_next} * 12'd10 + {8'd0, char_code[3:0]};
                            acc_next = (prod > {3'd0, ACC_SAT}) ? ACC_SAT : prod[8:0];
                            tok_next.digit = 1'b1;
                        end else begin
                            tok_next.bad = 1'b1;
                        end
                    end
                end
                MODE_BIN: begin
                    if (!is_sep(char_code)) begin
                        if (char_code == CH_ZERO || char_code == CH_ONE) begin
                            bs_next = {bs_next[6:0], char_code[0]};
                            if (bc_next == 3'd7) begin
                                if (error_next == ST_OK) begin
                                    r[n[1:0]] = make_byte(bs_next);
                                    n = n + 1'b1;
                                end
                                bc_next = 3'd0;
                                bs_next = 8'd0;
                            end else begin
                                bc_next = bc_next + 3'd1;
                            end
                        end else if (error_next == ST_OK) begin
                            error_next = ST_BAD_BIN;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (end_of_text) begin
            // judge leftovers of the current mode
            if (cfg.parse_mode == MODE_HEX && np_next) begin
                if (error_next == ST_OK) error_next = ST_ODD_NIB;
            end else if (cfg.parse_mode == MODE_DEC) begin
                if (tok_next.active) begin
                    if (token_good(tok_next, acc_next)) begin
                        if (error_next == ST_OK) begin
                            r[n[1:0]] = make_byte(acc_next[7:0]);
                            n = n + 1'b1;
                        end
                    end else if (error_next == ST_OK) begin
                        error_next = ST_BAD_DEC;
                    end
                end
            end else if (cfg.parse_mode == MODE_BIN && bc_next != 3'd0) begin
                if (error_next == ST_OK) error_next = ST_BAD_BIN;
            end

            if ((cfg.line_ending == LE_CR || cfg.line_ending == LE_CRLF) &&
                error_next == ST_OK) begin
                r[n[1:0]] = make_byte(BYTE_CR);
                n = n + 1'b1;
            end
            if ((cfg.line_ending == LE_LF || cfg.line_ending == LE_CRLF) &&
                error_next == ST_OK) begin
                r[n[1:0]] = make_byte(BYTE_LF);
                n = n + 1'b1;
            end

            r[n[1:0]].byte_value  = 8'd0;
            r[n[1:0]].has_byte    = 1'b0;
            r[n[1:0]].last_item   = 1'b1;
            r[n[1:0]].status_code = error_next;
            n = n + 1'b1;

            // start the next message clean
            error_next = ST_OK;
            hn_next    = '0;
            np_next    = 1'b0;
            bs_next    = '0;
            bc_next    = '0;
            acc_next   = '0;
            tok_next   = '0;
        end

        res     = r;
        res_cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_reg <= ST_OK;
            hn_reg    <= '0;
            np_reg    <= 1'b0;
            bs_reg    <= '0;
            bc_reg    <= '0;
            acc_reg   <= '0;
            tok_reg   <= '0;
        end else if (fire) begin
            error_reg <= error_next;
            hn_reg    <= hn_next;
            np_reg    <= np_next;
            bs_reg    <= bs_next;
            bc_reg    <= bc_next;
            acc_reg   <= acc_next;
            tok_reg   <= tok_next;
        end
    end

endmodule

[rtl/tbp_result_q.sv]
// ----------------------------------------------------------------------------
// tbp_result_q
// Result queue: takes up to four result items per cycle, hands out one.
// ----------------------------------------------------------------------------
module tbp_result_q
    import tbp_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  res_vec_t             push_data,
    input  logic [RES_CNT_W-1:0] push_cnt,
    output logic                 space_ok,
    output result_t              head,
    output logic                 head_valid,
    input  logic                 pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_pop;

    assign do_pop     = pop && head_valid;
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    // room for the largest burst one item can cause
    assign space_ok   = (count_reg <= CNT_W'(DEPTH - MAX_RESULTS));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (RES_CNT_W'(i) < push_cnt) begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/text_to_byte_payload_parser.sv]
// ----------------------------------------------------------------------------
// text_to_byte_payload_parser
// Turns the UTF-16 characters of a message into payload bytes (ascii, hex,
// decimal tokens or binary digits), appends the line ending and closes each
// message with a status item.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     char_code, has_char, end_of_text
//   m_        out        m_valid / m_ready     byte_value, has_byte, last_item,
//                                              status_code
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each accepted character is decoded in the cycle it is taken and its 0..4
// result items are written into the result queue at that edge; the first
// one shows on m_ once the items ahead of it in the queue have drained.
// The input takes one item per cycle while the queue has four free slots;
// the output drains one result per cycle while m_ready is high, so the
// result port sets the sustained rate.
// Reset clears the configuration, the message state and the queue.
// A stall on m_ drops s_ready once under four slots are free; no data is lost.
//
module text_to_byte_payload_parser
    import tbp_pkg::*;
#(
    parameter int FIFO_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_char_code,
    input  logic        s_has_char,
    input  logic        s_end_of_text,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic        m_has_byte,
    output logic        m_last_item,
    output logic [2:0]  m_status_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    cfg_t                 cfg_reg, cfg_next;
    logic                 fire;
    logic                 space_ok;
    res_vec_t             res;
    logic [RES_CNT_W-1:0] res_cnt;
    logic [RES_CNT_W-1:0] push_cnt;
    result_t              head;

    // Configuration: always ready; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PARSE_MODE:  cfg_next.parse_mode  = cfg_data;
                REG_LINE_ENDING: cfg_next.line_ending = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{parse_mode: MODE_ASCII, line_ending: LE_NONE};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input transfer: take a character whenever the queue can hold a full burst.
    assign s_ready = space_ok;
    assign fire    = s_valid && s_ready;

    tbp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .fire        (fire),
        .char_code   (s_char_code),
        .has_char    (s_has_char),
        .end_of_text (s_end_of_text),
        .res         (res),
        .res_cnt     (res_cnt)
    );

    // Only a real transfer pushes results.
    assign push_cnt = fire ? res_cnt : '0;

    tbp_result_q #(
        .DEPTH (FIFO_DEPTH)
    ) u_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (res),
        .push_cnt   (push_cnt),
        .space_ok   (space_ok),
        .head       (head),
        .head_valid (m_valid),
        .pop        (m_ready)
    );

    // Present the queue head; hold it until the consumer takes it.
    assign m_byte_value  = head.byte_value;
    assign m_has_byte    = head.has_byte;
    assign m_last_item   = head.last_item;
    assign m_status_code = head.status_code;

endmodule

[rtl/tbp_checker.sv]
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the text to byte payload parser, bound to its top.
// ----------------------------------------------------------------------------
module tbp_checker
    import tbp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_has_char,
    input logic        s_end_of_text,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_byte_value,
    input logic        m_has_byte,
    input logic        m_last_item,
    input logic [2:0]  m_status_code
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_value) &&
        $stable(m_has_byte) && $stable(m_last_item) && $stable(m_status_code))
        else $error("result changed while stalled");

    // No result straight out of reset.
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result shown right after reset");

    // An empty item into an empty queue produces nothing.
    a_empty_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_has_char && !s_end_of_text && !m_valid |=> !m_valid)
        else $error("empty item produced a result");

    // A status item never carries a byte, a byte item never a status.
    a_item_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_item != m_has_byte) &&
                    (m_has_byte ? m_status_code == ST_OK : m_byte_value == 8'd0))
        else $error("malformed result item");

endmodule

bind text_to_byte_payload_parser tbp_checker u_tbp_checker (.*);
